FILE: rtl/core/ptt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the priority task table.
// No dependencies; every other file of the block uses this package.
package ptt_pkg;

	// Default depth of the entry table.
	localparam int CAPACITY_DEF = 64;

	// Field widths of the request and result.
	localparam int CMD_W   = 3;
	localparam int POS_W   = 7;
	localparam int PRI_W   = 3;
	localparam int TAG_W   = 16;
	localparam int COUNT_W = 7;

	// Accepted range of priorities.
	localparam logic [PRI_W-1:0] PRI_MIN = 3'd1;
	localparam logic [PRI_W-1:0] PRI_MAX = 3'd5;

	// Command codes; codes above CMD_READ are ignored.
	localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_EDIT   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SORT   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_FULL   = 3'd1,
		ST_EMPTY  = 3'd2,
		ST_BADPOS = 3'd3,
		ST_BADPRI = 3'd4
	} status_t;

	// One request.
	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [POS_W-1:0] position;
		logic [PRI_W-1:0] priority_req;
		logic [TAG_W-1:0] tag;
	} cmd_t;

	// One result.
	typedef struct packed {
		status_t            status;
		logic [POS_W-1:0]   entry_number;
		logic [PRI_W-1:0]   entry_priority;
		logic [TAG_W-1:0]   entry_tag;
		logic [COUNT_W-1:0] entry_count;
		logic               last;
	} res_t;

	// One stored table entry.
	typedef struct packed {
		logic [PRI_W-1:0] pri;
		logic [TAG_W-1:0] tag;
	} entry_t;

endpackage

FILE: rtl/core/priority_task_table_unit.sv
`timescale 1ns / 1ps
// Flow: an accepted request is decoded; append, edit, error, unknown commands and a sort of at
// most one entry then load their result. Remove reads and writes each later entry down by one,
// then drops the top; a read-out has a decode step, then an issue and an emit step per entry.
// Sort passes walk the entries with the single memory read port and one priority compare.
// One request at a time; the next is taken after the final result loads and the sequencer idles.
// Reset clears the entry count and the handshake; the entry memory is not cleared.
// Top level of the priority task table: sequencer, entry memory and result register.
// Depends on ptt_pkg, ptt_store and ptt_seq.
module priority_task_table_unit #(
	parameter int CAPACITY = ptt_pkg::CAPACITY_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  ptt_pkg::cmd_t  cmd,
	output logic           res_valid,
	input  logic           res_stall,
	output ptt_pkg::res_t  res
);

	localparam int ADDR_W = $clog2(CAPACITY);

	logic             wr_en;
	logic [ADDR_W-1:0] wr_addr;
	ptt_pkg::entry_t  wr_data;
	logic             rd_en;
	logic [ADDR_W-1:0] rd_addr;
	ptt_pkg::entry_t  rd_data;
	logic             busy;
	logic             res_free;
	logic             res_load;
	ptt_pkg::res_t    res_data;
	logic             res_valid_q;
	ptt_pkg::res_t    res_q;

	ptt_store #(
		.DEPTH  (CAPACITY),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	ptt_seq #(
		.CAPACITY (CAPACITY)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.busy      (busy),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.res_free  (res_free),
		.res_load  (res_load),
		.res_data  (res_data)
	);

	// Requests wait while the sequencer works on one.
	assign cmd_stall = busy;

	// Output register: free when empty or being taken this cycle.
	assign res_free = !res_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_free) begin
			res_valid_q <= res_load;
		end
	end

	always_ff @(posedge clk) begin
		if (res_free && res_load) begin
			res_q <= res_data;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

FILE: rtl/core/ptt_store.sv
`timescale 1ns / 1ps
// Entry memory of the priority task table: one write port, one registered read port.
// Depends on ptt_pkg for the entry type.
module ptt_store #(
	parameter int DEPTH  = ptt_pkg::CAPACITY_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [ADDR_W-1:0]   wr_addr,
	input  ptt_pkg::entry_t     wr_data,
	input  logic                rd_en,
	input  logic [ADDR_W-1:0]   rd_addr,
	output ptt_pkg::entry_t     rd_data
);

	ptt_pkg::entry_t mem_q [DEPTH];
	ptt_pkg::entry_t rd_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port; the data register holds its value until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

FILE: rtl/core/ptt_seq.sv
`timescale 1ns / 1ps
// Command sequencer of the priority task table: decodes a request, then walks the
// entry memory for shifts, sorts and read-outs, with one priority compare for sorts.
// Depends on ptt_pkg.
module ptt_seq #(
	parameter  int CAPACITY = ptt_pkg::CAPACITY_DEF,
	localparam int AW       = $clog2(CAPACITY),
	localparam int CW       = $clog2(CAPACITY + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  ptt_pkg::cmd_t    cmd,
	output logic             busy,
	output logic             wr_en,
	output logic [AW-1:0]    wr_addr,
	output ptt_pkg::entry_t  wr_data,
	output logic             rd_en,
	output logic [AW-1:0]    rd_addr,
	input  ptt_pkg::entry_t  rd_data,
	input  logic             res_free,
	output logic             res_load,
	output ptt_pkg::res_t    res_data
);

	typedef enum logic [10:0] {
		ST_IDLE      = 11'b000_0000_0001,
		ST_DECODE    = 11'b000_0000_0010,
		ST_RESP      = 11'b000_0000_0100,
		ST_SH_RD     = 11'b000_0000_1000,
		ST_SH_WR     = 11'b000_0001_0000,
		ST_SRT_FIRST = 11'b000_0010_0000,
		ST_SRT_LOAD  = 11'b000_0100_0000,
		ST_SRT_CMP   = 11'b000_1000_0000,
		ST_SRT_END   = 11'b001_0000_0000,
		ST_RD_ISSUE  = 11'b010_0000_0000,
		ST_RD_EMIT   = 11'b100_0000_0000
	} state_t;

	state_t            state_q, state_d;
	ptt_pkg::status_t  status_q, status_d;
	logic [CW-1:0]     count_q, count_d;
	logic [CW-1:0]     limit_q, limit_d;
	logic [AW-1:0]     idx_q, idx_d;
	ptt_pkg::entry_t   carry_q, carry_d;
	ptt_pkg::cmd_t     req_q;

	logic              accept;
	logic              is_full;
	logic              is_empty;
	logic              pos_ok;
	logic              pri_ok;
	logic [AW-1:0]     pos_idx;
	logic [AW-1:0]     idx_inc;
	logic              carry_lt;
	logic              read_last;

	assign busy   = (state_q != ST_IDLE);
	assign accept = cmd_valid && (state_q == ST_IDLE);

	// Request checks against the current fill.
	assign is_full  = (count_q == CW'(CAPACITY));
	assign is_empty = (count_q == '0);
	assign pos_ok   = (req_q.position != '0)
		&& (req_q.position <= ptt_pkg::POS_W'(count_q));
	assign pri_ok   = (req_q.priority_req >= ptt_pkg::PRI_MIN)
		&& (req_q.priority_req <= ptt_pkg::PRI_MAX);
	assign pos_idx  = AW'(req_q.position - ptt_pkg::POS_W'(1));
	assign idx_inc  = idx_q + AW'(1);

	// The sort compare: does the carried entry sink below the next one?
	assign carry_lt  = (carry_q.pri < rd_data.pri);
	assign read_last = ((CW'(idx_q) + CW'(1)) == count_q);

	// Sequencer next state, memory port control and result formation.
	always_comb begin
		state_d  = state_q;
		status_d = status_q;
		count_d  = count_q;
		limit_d  = limit_q;
		idx_d    = idx_q;
		carry_d  = carry_q;
		wr_en    = 1'b0;
		wr_addr  = idx_q;
		wr_data  = carry_q;
		rd_en    = 1'b0;
		rd_addr  = idx_q;
		res_load = 1'b0;
		res_data = '{
			status:         status_q,
			entry_number:   '0,
			entry_priority: '0,
			entry_tag:      '0,
			entry_count:    ptt_pkg::COUNT_W'(count_q),
			last:           1'b1
		};
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				status_d = ptt_pkg::ST_OK;
				state_d  = ST_RESP;
				unique case (req_q.command)
					ptt_pkg::CMD_APPEND: begin
						if (is_full) begin
							status_d = ptt_pkg::ST_FULL;
						end else if (!pri_ok) begin
							status_d = ptt_pkg::ST_BADPRI;
						end else begin
							wr_en   = 1'b1;
							wr_addr = AW'(count_q);
							wr_data = '{pri: req_q.priority_req, tag: req_q.tag};
							count_d = count_q + CW'(1);
						end
					end
					ptt_pkg::CMD_REMOVE: begin
						if (is_empty) begin
							status_d = ptt_pkg::ST_EMPTY;
						end else if (!pos_ok) begin
							status_d = ptt_pkg::ST_BADPOS;
						end else begin
							idx_d   = pos_idx;
							state_d = ST_SH_RD;
						end
					end
					ptt_pkg::CMD_EDIT: begin
						if (is_empty) begin
							status_d = ptt_pkg::ST_EMPTY;
						end else if (!pos_ok) begin
							status_d = ptt_pkg::ST_BADPOS;
						end else if (!pri_ok) begin
							status_d = ptt_pkg::ST_BADPRI;
						end else begin
							wr_en   = 1'b1;
							wr_addr = pos_idx;
							wr_data = '{pri: req_q.priority_req, tag: req_q.tag};
						end
					end
					ptt_pkg::CMD_SORT: begin
						if (count_q > CW'(1)) begin
							limit_d = count_q;
							state_d = ST_SRT_FIRST;
						end
					end
					ptt_pkg::CMD_READ: begin
						if (is_empty) begin
							status_d = ptt_pkg::ST_EMPTY;
						end else begin
							idx_d   = '0;
							state_d = ST_RD_ISSUE;
						end
					end
					default: begin
					end
				endcase
			end
			// Remove: move each later entry down by one, then drop the top.
			ST_SH_RD: begin
				if ((CW'(idx_q) + CW'(1)) < count_q) begin
					rd_en   = 1'b1;
					rd_addr = idx_inc;
					state_d = ST_SH_WR;
				end else begin
					count_d = count_q - CW'(1);
					state_d = ST_RESP;
				end
			end
			ST_SH_WR: begin
				wr_en   = 1'b1;
				wr_addr = idx_q;
				wr_data = rd_data;
				idx_d   = idx_inc;
				state_d = ST_SH_RD;
			end
			// Sort pass: carry the entry that sinks and write back the other.
			ST_SRT_FIRST: begin
				idx_d   = '0;
				rd_en   = 1'b1;
				rd_addr = '0;
				state_d = ST_SRT_LOAD;
			end
			ST_SRT_LOAD: begin
				carry_d = rd_data;
				rd_en   = 1'b1;
				rd_addr = idx_inc;
				state_d = ST_SRT_CMP;
			end
			ST_SRT_CMP: begin
				wr_en   = 1'b1;
				wr_addr = idx_q;
				if (carry_lt) begin
					wr_data = rd_data;
				end else begin
					wr_data = carry_q;
					carry_d = rd_data;
				end
				idx_d = idx_inc;
				if ((CW'(idx_q) + CW'(2)) < limit_q) begin
					rd_en   = 1'b1;
					rd_addr = idx_q + AW'(2);
				end else begin
					state_d = ST_SRT_END;
				end
			end
			ST_SRT_END: begin
				wr_en   = 1'b1;
				wr_addr = idx_q;
				wr_data = carry_q;
				limit_d = limit_q - CW'(1);
				if (limit_q > CW'(2)) begin
					state_d = ST_SRT_FIRST;
				end else begin
					state_d = ST_RESP;
				end
			end
			// Read-out: one entry per result, the last one marked.
			ST_RD_ISSUE: begin
				rd_en   = 1'b1;
				rd_addr = idx_q;
				state_d = ST_RD_EMIT;
			end
			ST_RD_EMIT: begin
				res_data.status         = ptt_pkg::ST_OK;
				res_data.entry_number   = ptt_pkg::POS_W'(idx_q) + ptt_pkg::POS_W'(1);
				res_data.entry_priority = rd_data.pri;
				res_data.entry_tag      = rd_data.tag;
				res_data.last           = read_last;
				if (res_free) begin
					res_load = 1'b1;
					idx_d    = idx_inc;
					state_d  = read_last ? ST_IDLE : ST_RD_ISSUE;
				end
			end
			ST_RESP: begin
				if (res_free) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			status_q <= ptt_pkg::ST_OK;
			count_q  <= '0;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
			count_q  <= count_d;
		end
	end

	// Working registers of the walk and the held request.
	always_ff @(posedge clk) begin
		limit_q <= limit_d;
		idx_q   <= idx_d;
		carry_q <= carry_d;
		if (accept) begin
			req_q <= cmd;
		end
	end

`ifndef SYNTHESIS
	// A result is only formed when the output register can take it.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> res_free)
		else $error("result formed while output register is occupied");

	// The fill never exceeds the table depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count beyond capacity");

	// An accepted request is decoded in the next cycle.
	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_DECODE))
		else $error("accepted request not decoded");

	// The final result of a request returns the sequencer to idle.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && res_data.last) |=> (state_q == ST_IDLE))
		else $error("sequencer busy after final result");
`endif

endmodule
